@@ rtl/core/stir_pkg.sv @@
package stir_pkg;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    // Source of the data written into the table.
    typedef enum logic [0:0] {
        WSRC_KEY  = 1'b0,
        WSRC_READ = 1'b1
    } wsrc_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] count;
        logic       is_empty;
    } result_t;

    typedef struct packed {
        logic  load_key;
        logic  rd_en;
        logic  wr_en;
        wsrc_t wr_src;
    } dp_cmd_t;

    // Comparison of the last entry read against the key.
    typedef struct packed {
        logic ge;
        logic eq;
        logic gt;
    } dp_sts_t;

endpackage

@@ rtl/core/stir_datapath.sv @@
module stir_datapath #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic               clk,
    input  logic signed [31:0] value,
    input  stir_pkg::dp_cmd_t  cmd,
    input  logic [IDX_W-1:0]   rd_addr,
    input  logic [IDX_W-1:0]   wr_addr,
    output stir_pkg::dp_sts_t  sts
);
    import stir_pkg::*;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] key_reg;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] wr_data;

    assign wr_data = (cmd.wr_src == WSRC_READ) ? rd_data_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= value;
        end
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign sts.ge = (rd_data_reg >= key_reg);
    assign sts.eq = (rd_data_reg == key_reg);
    assign sts.gt = (rd_data_reg >  key_reg);

endmodule

@@ rtl/core/stir_ctrl.sv @@
module stir_ctrl #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                func,
    output logic                busy,
    output stir_pkg::dp_cmd_t   cmd,
    output logic [IDX_W-1:0]    rd_addr,
    output logic [IDX_W-1:0]    wr_addr,
    input  stir_pkg::dp_sts_t   sts,
    output logic                done,
    output stir_pkg::result_t   result
);
    import stir_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_LAST,
        ST_REM
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             found_reg, found_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;
    logic             finish;
    logic             fin_ok;
    logic             found_now;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        cmd         = '0;
        cmd.wr_src  = WSRC_KEY;
        rd_addr     = idx_reg;
        wr_addr     = idx_reg;
        finish      = 1'b0;
        fin_ok      = 1'b0;
        found_now   = found_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_key = 1'b1;
                    if (func == FUNC_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            finish = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = ST_INS_LAST;
                        end
                        else
                        begin
                            // Walk down from the top entry, moving each one up a slot.
                            cmd.rd_en  = 1'b1;
                            rd_addr    = IDX_W'(count_reg - 1'b1);
                            idx_next   = IDX_W'(count_reg - 1'b1);
                            state_next = ST_INS;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = ST_REM;
                        end
                    end
                end
            end

            ST_INS:
            begin
                cmd.wr_en = 1'b1;
                wr_addr   = idx_reg + 1'b1;
                if (sts.ge)
                begin
                    cmd.wr_src = WSRC_READ;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_INS_LAST;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_reg - 1'b1;
                        idx_next  = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_src = WSRC_KEY;
                    count_next = count_reg + 1'b1;
                    finish     = 1'b1;
                    fin_ok     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_INS_LAST:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WSRC_KEY;
                wr_addr    = '0;
                count_next = count_reg + 1'b1;
                finish     = 1'b1;
                fin_ok     = 1'b1;
                state_next = ST_IDLE;
            end

            ST_REM:
            begin
                if (found_reg)
                begin
                    // Close the gap: every entry after the match moves down a slot.
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = WSRC_READ;
                    wr_addr    = idx_reg - 1'b1;
                end
                else if (sts.eq)
                begin
                    found_now = 1'b1;
                end

                if (!found_reg && !sts.eq && sts.gt)
                begin
                    // Passed the place where the value would be, so it is absent.
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (CNT_W'(idx_reg) == count_reg - 1'b1)
                begin
                    finish     = 1'b1;
                    fin_ok     = found_now;
                    if (found_now)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    found_next = found_now;
                    cmd.rd_en  = 1'b1;
                    rd_addr    = idx_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        done_next            = finish;
        result_next          = result_reg;
        if (finish)
        begin
            result_next.ok       = fin_ok;
            result_next.count    = 5'(count_next);
            result_next.is_empty = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE)
        else $error("result strobe while an operation is still running");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> state_reg != ST_IDLE)
        else $error("table written while idle");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS_LAST |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not raise the count by one");
`endif

endmodule

@@ rtl/core/sorted_table_insert_remove.sv @@
// Sorted table of signed 32-bit values, duplicates allowed, up to CAPACITY entries.
// Pulse start with an item while busy is low; the transfer takes place on that edge.
// The table sits in a single-port-write, single-port-read memory, and each item walks
// it one entry per clock: an insert moves every entry not below the value up one slot,
// working down from the top, then writes the value into the slot left free; a remove
// scans upward from the bottom and then closes the gap. A refused insert into a full
// table or a remove from an empty table finishes in the cycle of the transfer, without
// raising busy. The result appears on result with done high for exactly one cycle, the
// first cycle in which busy is low again (the cycle right after the transfer when busy
// never rose); done cannot be held off, so the receiver must take it then.
module sorted_table_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  stir_pkg::in_item_t item,
    output logic               busy,
    output logic               done,
    output stir_pkg::result_t  result
);
    import stir_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    stir_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .func    (item.func),
        .busy    (busy),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

    stir_datapath #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_datapath (
        .clk     (clk),
        .value   (item.value),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .sts     (sts)
    );

endmodule
